// ===== design/cre_pkg.sv =====
// Shared constants, types and GF(2^8) helpers for the Cauchy RS encoder.
package cre_pkg;

    localparam int MAX_DATA   = 16;
    localparam int MAX_PARITY = 8;

    localparam int COL_W  = $clog2(MAX_DATA);
    localparam int ROW_W  = $clog2(MAX_PARITY);
    localparam int ND_W   = $clog2(MAX_DATA + 1);
    localparam int NP_W   = $clog2(MAX_PARITY + 1);
    localparam int CFG_W  = 5;
    localparam int IDX_W  = $clog2(MAX_DATA + MAX_PARITY);
    localparam int INV_N  = 1 << IDX_W;

    localparam logic [8:0] GF_POLY  = 9'h11D;
    localparam logic [8:0] GF_TOP   = 9'h100;
    localparam int         GF_ORDER = 255;

    // configuration register indexes
    localparam logic CFG_N_DATA   = 1'b0;
    localparam logic CFG_N_PARITY = 1'b1;

    typedef logic [MAX_PARITY-1:0][7:0] t_acc;

    typedef struct packed {
        t_acc             acc;
        logic [ROW_W-1:0] last_row;
        logic             mark;
    } t_stripe;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] x;
        logic [7:0] r;
        x = {1'b0, a};
        r = 8'd0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r = r ^ x[7:0];
            x = {x[7:0], 1'b0};
            if ((x & GF_TOP) != 9'd0) x = x ^ GF_POLY;
        end
        return r;
    endfunction

    function automatic logic [7:0] gf_inv(input logic [7:0] a);
        logic [7:0] r;
        logic [7:0] base;
        int         e;
        r    = 8'd1;
        base = a;
        e    = GF_ORDER - 1;
        if (a == 8'd0) return 8'd0;
        while (e != 0) begin
            if ((e & 1) != 0) r = gf_mul(r, base);
            base = gf_mul(base, base);
            e    = e >> 1;
        end
        return r;
    endfunction

    function automatic logic [INV_N-1:0][7:0] build_inv_tab();
        logic [INV_N-1:0][7:0] t;
        for (int i = 0; i < INV_N; i++) t[i] = gf_inv(8'(i));
        return t;
    endfunction

    // inverse table over every possible Cauchy denominator
    localparam logic [INV_N-1:0][7:0] INV_TAB = build_inv_tab();

endpackage

// ===== design/cre_front.sv =====
// Front end: takes data bytes, updates the parity accumulators, closes stripes.
module cre_front
    import cre_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_push,
    input  logic [7:0]       i_data_byte,
    input  logic             i_block_end,
    input  logic             i_q_full,
    output logic             o_full,
    output logic             o_q_push,
    output t_stripe          o_q_data
);

    logic [CFG_W-1:0] r_n_data;
    logic [NP_W-1:0]  r_n_parity;
    t_acc             r_acc;
    logic [COL_W-1:0] r_col;

    logic [ND_W-1:0]  nd_eff;
    logic [ROW_W-1:0] np_last;
    t_acc             acc_new;
    logic             close;
    logic             accept;

    always_comb begin
        if (r_n_data == '0)
            nd_eff = ND_W'(1);
        else if (r_n_data > CFG_W'(MAX_DATA))
            nd_eff = ND_W'(MAX_DATA);
        else
            nd_eff = ND_W'(r_n_data);

        if (r_n_parity == '0)
            np_last = '0;
        else if (r_n_parity > NP_W'(MAX_PARITY))
            np_last = ROW_W'(MAX_PARITY - 1);
        else
            np_last = ROW_W'(r_n_parity - NP_W'(1));
    end

    // one GF multiply-accumulate lane per parity row
    always_comb begin
        logic [IDX_W-1:0] idx;
        for (int p = 0; p < MAX_PARITY; p++) begin
            idx = (IDX_W'(nd_eff) + IDX_W'(p)) ^ IDX_W'(r_col);
            if (ROW_W'(p) <= np_last)
                acc_new[p] = r_acc[p] ^ gf_mul(INV_TAB[idx], i_data_byte);
            else
                acc_new[p] = r_acc[p];
        end
    end

    assign close  = ND_W'(r_col) >= (nd_eff - ND_W'(1));
    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;

    assign o_q_push          = accept && close;
    assign o_q_data.acc      = acc_new;
    assign o_q_data.last_row = np_last;
    assign o_q_data.mark     = i_block_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_data   <= CFG_W'(4);
            r_n_parity <= NP_W'(2);
            r_acc      <= '0;
            r_col      <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_N_DATA)
                    r_n_data <= i_cfg_data;
                else
                    r_n_parity <= i_cfg_data[NP_W-1:0];
            end
            if (accept) begin
                if (close) begin
                    r_acc <= '0;
                    r_col <= '0;
                end else begin
                    r_acc <= acc_new;
                    r_col <= r_col + COL_W'(1);
                end
            end
        end
    end

endmodule

// ===== design/cre_queue.sv =====
// Two-entry queue of closed stripes between front and back.
module cre_queue
    import cre_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_stripe i_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_valid,
    output t_stripe o_data
);

    t_stripe    r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wr <= ~r_wr;
            if (do_pop)  r_rd <= ~r_rd;
            if (do_push && !do_pop)
                r_cnt <= r_cnt + 2'd1;
            else if (do_pop && !do_push)
                r_cnt <= r_cnt - 2'd1;
        end
    end

endmodule

// ===== design/cre_back.sv =====
// Back end: holds one closed stripe and hands out its parity bytes row by row.
module cre_back
    import cre_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_stripe          i_q_data,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [7:0]       o_parity_byte,
    output logic [ROW_W-1:0] o_parity_row,
    output logic             o_stripe_last,
    output logic             o_block_last
);

    t_stripe          r_cur;
    logic             r_valid;
    logic [ROW_W-1:0] r_row;

    logic take;
    logic last;
    logic load;

    assign last    = r_row == r_cur.last_row;
    assign take    = i_pop && r_valid;
    assign load    = i_q_valid && (!r_valid || (take && last));
    assign o_q_pop = load;

    assign o_empty       = !r_valid;
    assign o_parity_byte = r_cur.acc[r_row];
    assign o_parity_row  = r_row;
    assign o_stripe_last = last;
    assign o_block_last  = r_cur.mark;

    always_ff @(posedge i_clk) begin
        if (load) r_cur <= i_q_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_row   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_row   <= '0;
        end else if (take) begin
            if (last)
                r_valid <= 1'b0;
            r_row <= r_row + ROW_W'(1);
        end
    end

endmodule

// ===== design/cauchy_rs_erasure_encoder_core.sv =====
// Top level of the Cauchy Reed-Solomon GF(2^8) parity encoder.
// Takes one data byte per cycle unless full, columns of one stripe in order; all active parity
// rows are updated in parallel by per-row GF multiply-XOR lanes, so input never
// waits on arithmetic. When a byte closes a stripe, the finished accumulators go
// into a two-entry stripe queue and the output stage hands out one parity byte
// per cycle while pop is held, row 0 first. The input reports full only while
// that queue holds two closed stripes; with n_parity rows per stripe and n_data
// bytes per stripe, the sustained rate is one byte per cycle as long as
// n_parity <= n_data and pop is held, otherwise set by the single output port.
// Configuration writes are always ready and take effect on the next byte.
module cauchy_rs_erasure_encoder_core
    import cre_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       i_data_byte,
    input  logic             i_block_end,
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       o_parity_byte,
    output logic [ROW_W-1:0] o_parity_row,
    output logic             o_stripe_last,
    output logic             o_block_last
);

    logic    q_push;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    t_stripe q_in;
    t_stripe q_out;

    assign o_cfg_ready = 1'b1;

    cre_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_block_end (i_block_end),
        .i_q_full    (q_full),
        .o_full      (full),
        .o_q_push    (q_push),
        .o_q_data    (q_in)
    );

    cre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    cre_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_data      (q_out),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_parity_byte (o_parity_byte),
        .o_parity_row  (o_parity_row),
        .o_stripe_last (o_stripe_last),
        .o_block_last  (o_block_last)
    );

endmodule

// ===== bench/cauchy_rs_erasure_encoder_core_tb.sv =====
// Self-checking testbench for the Cauchy RS GF(2^8) parity encoder core.
`timescale 1ns / 100ps

module cauchy_rs_erasure_encoder_core_tb;
    import cre_pkg::*;

    localparam int SETTLE     = 16;
    localparam int STALL_MAX  = 2000;
    localparam int RAND_ITEMS = 90;

    typedef enum logic [1:0] {CMD_DATA, CMD_CFG, CMD_SETTLE} t_cmd_kind;

    typedef struct {
        t_cmd_kind        kind;
        logic [7:0]       data;
        logic             blk_end;
        logic             cfg_idx;
        logic [CFG_W-1:0] cfg_val;
    } t_cmd;

    typedef struct packed {
        logic [7:0]       pbyte;
        logic [ROW_W-1:0] row;
        logic             stripe_last;
        logic             block_last;
    } t_parity;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic             i_cfg_index = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             push = 1'b0;
    logic             full;
    logic [7:0]       i_data_byte = 8'd0;
    logic             i_block_end = 1'b0;
    logic             empty;
    logic             pop = 1'b0;
    logic [7:0]       o_parity_byte;
    logic [ROW_W-1:0] o_parity_row;
    logic             o_stripe_last;
    logic             o_block_last;

    cauchy_rs_erasure_encoder_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_data_byte   (i_data_byte),
        .i_block_end   (i_block_end),
        .empty         (empty),
        .pop           (pop),
        .o_parity_byte (o_parity_byte),
        .o_parity_row  (o_parity_row),
        .o_stripe_last (o_stripe_last),
        .o_block_last  (o_block_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_cmd    stim_q[$];
    t_parity parity_q[$];

    // encoder model state
    logic [7:0] inv_lut [256];
    logic [7:0] row_acc [MAX_PARITY];
    int         col_pos;
    logic [4:0] nd_reg;
    logic [3:0] np_reg;

    // stripe planning state, kept apart from the model
    logic [4:0] plan_nd;
    int         plan_col;
    int         planned;

    int  bytes_in;
    int  results_seen;
    int  cfg_writes;
    int  fails;
    int  quiet;
    int  stall;
    logic calm;

    assign calm = (bytes_in >= 70) && (bytes_in < 110);

    function automatic logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] sh;
        acc = 8'd0;
        sh  = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc = acc ^ sh;
            sh = {sh[6:0], 1'b0} ^ (sh[7] ? 8'h1D : 8'h00);
        end
        return acc;
    endfunction

    function automatic int eff_cols(logic [4:0] v);
        if (v == 5'd0) return 1;
        if (v > MAX_DATA) return MAX_DATA;
        return int'(v);
    endfunction

    function automatic int eff_rows(logic [3:0] v);
        if (v == 4'd0) return 1;
        if (v > MAX_PARITY) return MAX_PARITY;
        return int'(v);
    endfunction

    task automatic encode_byte(logic [7:0] d, logic blk_end);
        int      nd;
        int      np;
        t_parity r;
        nd = eff_cols(nd_reg);
        np = eff_rows(np_reg);
        for (int p = 0; p < np; p++)
            row_acc[p] = row_acc[p] ^ gf_times(inv_lut[8'(nd + p) ^ 8'(col_pos)], d);
        if (col_pos + 1 >= nd) begin
            for (int p = 0; p < np; p++) begin
                r.pbyte       = row_acc[p];
                r.row         = ROW_W'(p);
                r.stripe_last = (p + 1 == np);
                r.block_last  = blk_end;
                parity_q.push_back(r);
            end
            for (int p = 0; p < MAX_PARITY; p++) row_acc[p] = 8'd0;
            col_pos = 0;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        case (idx)
            CFG_N_DATA:   nd_reg = val[4:0];
            CFG_N_PARITY: np_reg = val[3:0];
            default:      nd_reg = nd_reg;
        endcase
    endtask

    task automatic add_byte(logic [7:0] d, logic blk_end);
        t_cmd c;
        c.kind    = CMD_DATA;
        c.data    = d;
        c.blk_end = blk_end;
        c.cfg_idx = CFG_N_DATA;
        c.cfg_val = '0;
        stim_q.push_back(c);
        planned++;
        if (plan_col + 1 >= eff_cols(plan_nd)) plan_col = 0;
        else plan_col++;
    endtask

    task automatic add_cfg(logic idx, logic [CFG_W-1:0] val);
        t_cmd c;
        c.kind    = CMD_CFG;
        c.data    = 8'd0;
        c.blk_end = 1'b0;
        c.cfg_idx = idx;
        c.cfg_val = val;
        stim_q.push_back(c);
        if (idx == CFG_N_DATA) plan_nd = val[4:0];
    endtask

    task automatic add_settle();
        t_cmd c;
        c.kind    = CMD_SETTLE;
        c.data    = 8'd0;
        c.blk_end = 1'b0;
        c.cfg_idx = CFG_N_DATA;
        c.cfg_val = '0;
        stim_q.push_back(c);
    endtask

    // bytes left to close the stripe from where the plan stands
    function automatic int bytes_to_close();
        int nd;
        nd = eff_cols(plan_nd);
        if (plan_col + 1 >= nd) return 1;
        return nd - plan_col;
    endfunction

    task automatic add_stripe();
        int n;
        n = bytes_to_close();
        for (int i = 0; i < n; i++) begin
            if (i == n - 1) add_byte(8'($urandom), 1'($urandom_range(0, 1)));
            else add_byte(8'($urandom), ($urandom_range(0, 99) < 20));
        end
    endtask

    // driver: data items and register writes, one per handshake
    always @(posedge i_clk) begin : drv
        logic nxt_push;
        logic nxt_cfg;
        t_cmd c;
        if (!i_rst_n) begin
            push        <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            nxt_push = push;
            nxt_cfg  = i_cfg_valid;
            if (push && !full) begin
                encode_byte(i_data_byte, i_block_end);
                bytes_in++;
                nxt_push = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                write_reg(i_cfg_index, i_cfg_data);
                cfg_writes++;
                nxt_cfg = 1'b0;
            end
            if (push && !full) quiet = 0;
            else if (parity_q.size() == 0 && empty) quiet++;
            else quiet = 0;

            if (!nxt_push && !nxt_cfg && stim_q.size() > 0) begin
                case (stim_q[0].kind)
                    CMD_DATA: begin
                        if (calm || $urandom_range(0, 99) >= 31) begin
                            c = stim_q.pop_front();
                            nxt_push = 1'b1;
                            i_data_byte <= c.data;
                            i_block_end <= c.blk_end;
                        end
                    end
                    CMD_CFG: begin
                        if (quiet >= SETTLE) begin
                            c = stim_q.pop_front();
                            nxt_cfg = 1'b1;
                            i_cfg_index <= c.cfg_idx;
                            i_cfg_data  <= c.cfg_val;
                        end
                    end
                    default: begin
                        if (quiet >= SETTLE) c = stim_q.pop_front();
                    end
                endcase
            end
            push        <= nxt_push;
            i_cfg_valid <= nxt_cfg;
        end
    end

    // monitor: every popped parity item against the oldest expectation
    always @(posedge i_clk) begin : mon
        t_parity e;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                results_seen++;
                if (parity_q.size() == 0) begin
                    $error("unexpected parity item: parity_byte %0h row %0d",
                           o_parity_byte, o_parity_row);
                    fails++;
                end else begin
                    e = parity_q.pop_front();
                    if (o_parity_byte !== e.pbyte) begin
                        $error("parity_byte mismatch: expected %0h, actual %0h",
                               e.pbyte, o_parity_byte);
                        fails++;
                    end
                    if (o_parity_row !== e.row) begin
                        $error("parity_row mismatch: expected %0d, actual %0d",
                               e.row, o_parity_row);
                        fails++;
                    end
                    if (o_stripe_last !== e.stripe_last) begin
                        $error("stripe_last mismatch: expected %0b, actual %0b",
                               e.stripe_last, o_stripe_last);
                        fails++;
                    end
                    if (o_block_last !== e.block_last) begin
                        $error("block_last mismatch: expected %0b, actual %0b",
                               e.block_last, o_block_last);
                        fails++;
                    end
                end
            end
            pop <= calm || ($urandom_range(0, 99) >= 31);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            stall = 0;
        else
            stall++;
        if (stall >= STALL_MAX) begin
            $display("watchdog: no handshake for %0d cycles", STALL_MAX);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [4:0] v;
        int         n;
        bytes_in     = 0;
        results_seen = 0;
        cfg_writes   = 0;
        fails        = 0;
        quiet        = 0;
        stall        = 0;
        planned      = 0;
        col_pos      = 0;
        nd_reg       = 5'd4;
        np_reg       = 4'd2;
        plan_nd      = 5'd4;
        plan_col     = 0;
        for (int p = 0; p < MAX_PARITY; p++) row_acc[p] = 8'd0;
        for (int a = 0; a < 256; a++) inv_lut[a] = 8'd0;
        for (int a = 1; a < 256; a++)
            for (int b = 1; b < 256; b++)
                if (gf_times(8'(a), 8'(b)) == 8'd1) inv_lut[a] = 8'(b);

        // reset sizes, byte extremes
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h80, 1'b0);
        add_byte(8'h01, 1'b1);
        // one column, all eight rows
        add_cfg(CFG_N_DATA, 5'd1);
        add_cfg(CFG_N_PARITY, 5'd8);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h55, 1'b0);
        // sizes change mid-stripe: column runs past n_data, rows drop,
        // and one denominator hits zero
        add_cfg(CFG_N_DATA, 5'd4);
        add_byte(8'hA7, 1'b1);
        add_byte(8'h3C, 1'b0);
        add_cfg(CFG_N_PARITY, 5'd3);
        add_cfg(CFG_N_DATA, 5'd2);
        add_byte(8'hC3, 1'b1);
        // zero sizes saturate up to one
        add_cfg(CFG_N_DATA, 5'd0);
        add_cfg(CFG_N_PARITY, 5'd0);
        add_byte(8'h5A, 1'b1);
        // oversize values saturate to the maximum; block_end on inner bytes ignored
        add_cfg(CFG_N_DATA, 5'd31);
        add_cfg(CFG_N_PARITY, 5'd31);
        for (int i = 0; i < 16; i++) add_byte(8'($urandom), (i % 2 == 0));

        planned = 0;
        while (planned < RAND_ITEMS) begin
            if ($urandom_range(0, 3) != 0) begin
                n = $urandom_range(0, 9);
                if (n < 6) v = 5'($urandom_range(1, 6));
                else if (n < 8) v = 5'($urandom_range(7, 16));
                else v = ($urandom_range(0, 1) != 0) ? 5'd0 : 5'($urandom_range(17, 31));
                add_cfg(CFG_N_DATA, v);
            end
            if ($urandom_range(0, 3) != 0) begin
                n = $urandom_range(0, 9);
                if (n < 8) v = 5'($urandom_range(1, 8));
                else v = ($urandom_range(0, 1) != 0) ? 5'd0 : 5'($urandom_range(9, 31));
                add_cfg(CFG_N_PARITY, v);
            end
            n = $urandom_range(1, 4);
            for (int s = 0; s < n; s++) begin
                if ($urandom_range(0, 99) < 12) begin
                    // broken stripe: can stop short, the next phase picks it up
                    for (int k = $urandom_range(1, bytes_to_close()); k > 0; k--)
                        add_byte(8'($urandom), 1'($urandom_range(0, 1)));
                end else begin
                    add_stripe();
                end
            end
            if (planned >= RAND_ITEMS / 2 && planned < RAND_ITEMS / 2 + 20) add_settle();
        end
        add_cfg(CFG_N_DATA, 5'd16);
        add_cfg(CFG_N_PARITY, 5'd8);
        add_stripe();
        add_stripe();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || push || i_cfg_valid || parity_q.size() != 0)
            @(posedge i_clk);
        repeat (4 * SETTLE) @(posedge i_clk);
        if (parity_q.size() != 0) begin
            $error("%0d expected parity items never arrived", parity_q.size());
            fails++;
        end

        $display("Fed %0d data bytes and made %0d register writes over sizes 1..16 x 1..8,",
                 bytes_in, cfg_writes);
        $display("including saturated and mid-stripe size changes; %0d parity items checked.",
                 results_seen);
        if (fails == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
